// ===== src/sha256_hash_engine_core_defines.svh =====
// Assertion macros used by the checker file of the SHA-256 hash engine.
`ifndef SHA256_HASH_ENGINE_CORE_DEFINES_SVH
`define SHA256_HASH_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define SHA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sha256_pkg.sv =====
// Shared types and constants of the SHA-256 hash engine.
`default_nettype none

package sha256_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

`default_nettype wire

// ===== src/sha256_hash_engine_core.sv =====
// Top level of the streaming SHA-256 hash engine, one message byte per item.
// A byte item that does not fill the block leaves the engine idle for the next one; the item that
// fills a 64-byte block starts 64 rounds and a fold. A finishing item feeds 9 to 72 padding bytes
// at one a cycle, runs one or two compressions, then gives eight digest words at one per cycle unless stalled.
// A single round unit computes one round per cycle.
// Synchronous reset restores the initial hash values and clears the byte count.
`default_nettype none

module sha256_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        final_word
);

  typedef enum logic [2:0] {
    IDLE,
    PAD,
    COMPRESS,
    FOLD,
    EMIT
  } state_t;

  state_t state;

  // Hash state, byte count and the block write pointer.
  logic [31:0] hash [8];
  logic [63:0] byte_total;
  logic [5:0]  fill_pos;
  logic [5:0]  round;
  logic [2:0]  out_cnt;

  // Padding control. The mark byte goes first; the length bytes go only into the
  // block that ends the message, which len_ok tells apart from a block that the
  // mark byte spilled past the length field.
  logic pad_mark;
  logic len_ok;
  logic pad_pending;
  logic last_block;

  // Working variables, schedule window and the bit length shifted out MSB first.
  sha256_pkg::work_t work;
  sha256_pkg::work_t work_next;
  logic [31:0] sched [16];
  logic [31:0] sched_word;
  logic [63:0] len_shift;

  logic        accept;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        len_write;
  logic        block_full;
  logic        emit_take;
  logic [63:0] total_next;

  assign accept     = data_valid && (state == IDLE);
  assign emit_take  = digest_valid && !digest_stall;
  assign total_next = byte_total + {63'd0, byte_present};
  assign len_write  = (state == PAD) && !pad_mark && len_ok && (fill_pos >= sha256_pkg::LEN_POS);

  // Byte write into the block, either a message byte or a padding byte.
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = data_byte;
    if (state == IDLE) begin
      wr_en = accept && byte_present;
    end else if (state == PAD) begin
      wr_en = 1'b1;
      if (pad_mark) begin
        wr_byte = sha256_pkg::PAD_MARK;
      end else if (len_write) begin
        wr_byte = len_shift[63:56];
      end else begin
        wr_byte = 8'h00;
      end
    end
  end

  assign block_full = wr_en && (fill_pos == sha256_pkg::LAST_POS);

  sha256_round u_round (
    .work       (work),
    .k_word     (sha256_pkg::ROUND_K[round]),
    .w0         (sched[0]),
    .w1         (sched[1]),
    .w9         (sched[9]),
    .w14        (sched[14]),
    .work_next  (work_next),
    .sched_word (sched_word)
  );

  // Sequencer: state, hash words, counters and the output word counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      hash        <= sha256_pkg::INIT_H;
      byte_total  <= 64'd0;
      fill_pos    <= 6'd0;
      round       <= 6'd0;
      out_cnt     <= 3'd0;
      pad_mark    <= 1'b0;
      len_ok      <= 1'b0;
      pad_pending <= 1'b0;
      last_block  <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_pos <= fill_pos + 6'd1;
      end
      if (state != COMPRESS) begin
        round <= 6'd0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            byte_total <= total_next;
            if (end_of_message) begin
              pad_pending <= 1'b1;
              pad_mark    <= 1'b1;
              last_block  <= 1'b0;
            end
            if (block_full) begin
              state <= COMPRESS;
            end else if (end_of_message) begin
              state <= PAD;
            end
          end
        end
        PAD: begin
          pad_mark <= 1'b0;
          // Once a padded block wraps, the next one carries the length.
          if (fill_pos == sha256_pkg::LAST_POS) begin
            len_ok     <= 1'b1;
            last_block <= len_write;
            state      <= COMPRESS;
          end else if (pad_mark) begin
            len_ok <= (fill_pos < sha256_pkg::LEN_POS);
          end
        end
        COMPRESS: begin
          round <= round + 6'd1;
          if (round == sha256_pkg::LAST_ROUND) begin
            state <= FOLD;
          end
        end
        FOLD: begin
          hash[0] <= hash[0] + work.a;
          hash[1] <= hash[1] + work.b;
          hash[2] <= hash[2] + work.c;
          hash[3] <= hash[3] + work.d;
          hash[4] <= hash[4] + work.e;
          hash[5] <= hash[5] + work.f;
          hash[6] <= hash[6] + work.g;
          hash[7] <= hash[7] + work.h;
          if (last_block) begin
            pad_pending <= 1'b0;
            out_cnt     <= 3'd0;
            state       <= EMIT;
          end else if (pad_pending) begin
            state <= PAD;
          end else begin
            state <= IDLE;
          end
        end
        EMIT: begin
          // The digest leaves from hash[0]; initial values refill from the back,
          // so the hash state is ready for the next message after word seven.
          if (emit_take) begin
            for (int j = 0; j < 7; j++) begin
              hash[j] <= hash[j + 1];
            end
            hash[7] <= sha256_pkg::INIT_H[out_cnt];
            out_cnt <= out_cnt + 3'd1;
            if (out_cnt == sha256_pkg::LAST_WORD) begin
              byte_total <= 64'd0;
              last_block <= 1'b0;
              state      <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Datapath registers: block and schedule window, working variables, length.
  always_ff @(posedge clk) begin
    if (accept && end_of_message) begin
      len_shift <= {total_next[60:0], 3'b000};
    end else if (len_write) begin
      len_shift <= {len_shift[55:0], 8'h00};
    end

    if (wr_en) begin
      case (fill_pos[1:0])
        2'd0: sched[fill_pos[5:2]][31:24] <= wr_byte;
        2'd1: sched[fill_pos[5:2]][23:16] <= wr_byte;
        2'd2: sched[fill_pos[5:2]][15:8]  <= wr_byte;
        2'd3: sched[fill_pos[5:2]][7:0]   <= wr_byte;
      endcase
    end else if (state == COMPRESS) begin
      for (int j = 0; j < 15; j++) begin
        sched[j] <= sched[j + 1];
      end
      sched[15] <= sched_word;
    end

    if (block_full) begin
      work <= {hash[0], hash[1], hash[2], hash[3], hash[4], hash[5], hash[6], hash[7]};
    end else if (state == COMPRESS) begin
      work <= work_next;
    end
  end

  assign data_stall   = (state != IDLE);
  assign digest_valid = (state == EMIT);
  assign digest_word  = hash[0];
  assign word_number  = out_cnt;
  assign final_word   = (out_cnt == sha256_pkg::LAST_WORD);

endmodule

`default_nettype wire

// ===== src/sha256_round.sv =====
// One SHA-256 compression round together with one message schedule step.
`default_nettype none

module sha256_round (
  input  sha256_pkg::work_t work,
  input  logic [31:0]       k_word,
  input  logic [31:0]       w0,
  input  logic [31:0]       w1,
  input  logic [31:0]       w9,
  input  logic [31:0]       w14,
  output sha256_pkg::work_t work_next,
  output logic [31:0]       sched_word
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    return 32'({x, x} >> n);
  endfunction

  logic [31:0] big1;
  logic [31:0] choose;
  logic [31:0] t1;
  logic [31:0] big0;
  logic [31:0] major;
  logic [31:0] s0;
  logic [31:0] s1;

  assign big1   = rotr(work.e, 5'd6) ^ rotr(work.e, 5'd11) ^ rotr(work.e, 5'd25);
  assign choose = (work.e & work.f) ^ (~work.e & work.g);
  assign t1     = work.h + big1 + choose + k_word + w0;
  assign big0   = rotr(work.a, 5'd2) ^ rotr(work.a, 5'd13) ^ rotr(work.a, 5'd22);
  assign major  = (work.a & work.b) ^ (work.a & work.c) ^ (work.b & work.c);

  assign work_next = '{
    a: t1 + big0 + major,
    b: work.a,
    c: work.b,
    d: work.c,
    e: work.d + t1,
    f: work.e,
    g: work.f,
    h: work.g
  };

  // The window holds W[i] .. W[i+15]; this forms W[i+16].
  assign s0 = rotr(w1, 5'd7) ^ rotr(w1, 5'd18) ^ (w1 >> 3);
  assign s1 = rotr(w14, 5'd17) ^ rotr(w14, 5'd19) ^ (w14 >> 10);
  assign sched_word = s1 + w9 + s0 + w0;

endmodule

`default_nettype wire

// ===== src/sha256_checker.sv =====
// Port-level checker of the SHA-256 hash engine and its bind to the top level.
`default_nettype none
`include "sha256_hash_engine_core_defines.svh"

module sha256_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        data_stall,
  input wire logic        digest_valid,
  input wire logic        digest_stall,
  input wire logic [2:0]  word_number,
  input wire logic        final_word
);

  `SHA_ASSERT_IMPL(a_final_tag, digest_valid, final_word == (word_number == 3'd7), "final flag off word seven")
  `SHA_ASSERT_IMPL(a_no_input_during_digest, digest_valid, data_stall, "item taken during digest output")
  `SHA_ASSERT_IMPL(a_first_word, $rose(digest_valid), word_number == 3'd0, "digest does not start at word zero")
  `SHA_ASSERT_NEXT(a_word_step, digest_valid && !digest_stall && !final_word, digest_valid && (word_number == $past(word_number) + 3'd1), "digest words not consecutive")
  `SHA_ASSERT_NEXT(a_digest_ends, digest_valid && !digest_stall && final_word, !digest_valid, "digest runs past word seven")

endmodule

bind sha256_hash_engine_core sha256_checker u_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the streaming SHA-256 hash engine core.

module testbench;

  // ---------------------------------------------------------------------------
  // Constants of the hash, kept here on purpose so that the expected digests do
  // not share a table with the design under test.
  // ---------------------------------------------------------------------------
  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles to keep watching the output once every digest word has arrived.
  localparam int unsigned SETTLE_CYCLES = 300;
  // Accepted items between these counts see no idling on either side.
  localparam int unsigned CALM_FIRST = 120;
  localparam int unsigned CALM_LAST = 200;

  // One item on the byte channel, plus a flag that tells the driver to hold it
  // back until every digest word predicted so far has been received.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       drain;
  } msg_item_t;

  // One digest word as it is expected on the output channel.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals of the design under test.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  sha256_hash_engine_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_stall   (digest_stall),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .final_word     (final_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping.
  // ---------------------------------------------------------------------------
  msg_item_t feed_queue[$];   // items still to be offered to the engine
  digest_t   digest_due[$];   // digest words predicted but not yet received

  int unsigned items_taken = 0;      // items accepted by the engine
  int unsigned words_predicted = 0;  // digest words pushed into digest_due
  int unsigned words_seen = 0;       // digest words taken off digest_due
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned random_items = 0;     // items queued by the random part

  // Both sides run without idling for a stretch of the run, so that the engine
  // also sees back-to-back traffic.
  wire calm = (items_taken >= CALM_FIRST) && (items_taken < CALM_LAST);

  // ---------------------------------------------------------------------------
  // Expected-digest computation: its own copy of the running hash, the block
  // being filled and the byte count of the current message.
  // ---------------------------------------------------------------------------
  logic [31:0] sha_state [8];
  logic [7:0]  block_bytes [64];
  logic [63:0] msg_len;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Runs the 64 rounds over block_bytes and adds the result into sha_state.
  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = sha_state[0]; b = sha_state[1]; c = sha_state[2]; d = sha_state[3];
    e = sha_state[4]; f = sha_state[5]; g = sha_state[6]; h = sha_state[7];
    for (i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    sha_state[0] += a; sha_state[1] += b; sha_state[2] += c; sha_state[3] += d;
    sha_state[4] += e; sha_state[5] += f; sha_state[6] += g; sha_state[7] += h;
  endtask

  // Absorbs one accepted item. A finishing item pads the message, queues the
  // eight digest words and starts over from the initial hash values.
  task automatic hash_item(input msg_item_t it);
    logic [63:0] bit_len;
    int pos;
    int i;
    if (it.present) begin
      pos = int'(msg_len[5:0]);
      block_bytes[pos] = it.data;
      msg_len = msg_len + 64'd1;
      if (pos == 63) fold_block();
    end
    if (it.last) begin
      bit_len = msg_len << 3;
      pos = int'(msg_len[5:0]);
      block_bytes[pos] = PAD_BYTE;
      for (i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // With no room left for the length, the padding spills into a second block.
      if (pos >= 56) begin
        fold_block();
        for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      for (i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
      fold_block();
      for (i = 0; i < 8; i++) begin
        digest_due.push_back('{word: sha_state[i], num: 3'(i), last: (i == 7)});
      end
      for (i = 0; i < 8; i++) sha_state[i] = START_HASH[i];
      msg_len = 64'd0;
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < 8; i++) sha_state[i] = START_HASH[i];
    for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    msg_len = 64'd0;
  end

  // ---------------------------------------------------------------------------
  // Driver. The payload only changes when the channel is empty or the current
  // item is taken, so a stalled item stays put. An item flagged for draining is
  // held back until the predicted and received word counts agree; both counts
  // are registers, so the comparison sees last cycle's values, and an item taken
  // in this cycle defers the check.
  // ---------------------------------------------------------------------------
  msg_item_t cur_item;

  always @(posedge clk) begin
    logic took;
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      took = data_valid && !data_stall;
      if (took) begin
        hash_item(cur_item);
        items_taken <= items_taken + 1;
        if (cur_item.last) words_predicted <= words_predicted + 8;
      end
      if (!data_valid || took) begin
        if (feed_queue.size() != 0 && (calm || $urandom_range(99) >= 25) &&
            !(feed_queue[0].drain && (took || words_predicted != words_seen))) begin
          cur_item = feed_queue.pop_front();
          data_valid <= 1'b1;
          data_byte <= cur_item.data;
          byte_present <= cur_item.present;
          end_of_message <= cur_item.last;
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every word taken from the engine is checked field by field against
  // the oldest prediction; the stall is redrawn every cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_t want;
    if (!rst && digest_valid && !digest_stall) begin
      if (digest_due.size() == 0) begin
        $display("%0t: digest word %h arrived with none expected", $time, digest_word);
        mismatches++;
      end else begin
        want = digest_due.pop_front();
        words_seen <= words_seen + 1;
        if (digest_word !== want.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, want.word, digest_word);
          mismatches++;
        end
        if (word_number !== want.num) begin
          $display("%0t: word_number expected %0d actual %0d", $time, want.num, word_number);
          mismatches++;
        end
        if (final_word !== want.last) begin
          $display("%0t: final_word expected %b actual %b", $time, want.last, final_word);
          mismatches++;
        end
      end
    end
    digest_stall <= !calm && ($urandom_range(99) < 25);
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a hung engine or a lost digest word ends the run here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  function automatic void push_item(input logic [7:0] d, input logic p, input logic l,
                                    input logic drain);
    feed_queue.push_back('{data: d, present: p, last: l, drain: drain});
  endfunction

  // Queues a message of random bytes. The finish comes either with the last
  // byte or as a separate item without a byte; idle items are sprinkled in.
  task automatic queue_message(input int len, input logic drain);
    logic split;
    int k;
    split = (len == 0) || ($urandom_range(99) < 30);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(99) < 6) begin
        push_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
        random_items++;
      end
      push_item(8'($urandom_range(255)), 1'b1, !split && (k == len - 1),
                drain && (k == 0));
    end
    if (split) push_item(8'($urandom_range(255)), 1'b0, 1'b1, drain && (len == 0));
    random_items += len + int'(split);
  endtask

  initial begin
    int pick;
    int len;

    // Directed part. The empty message comes first, straight out of reset.
    push_item(8'h00, 1'b0, 1'b1, 1'b0);
    // An idle item must leave the state alone.
    push_item(8'hff, 1'b0, 1'b0, 1'b0);
    // Single-byte messages at both ends of the byte range, byte and finish together.
    push_item(8'h00, 1'b1, 1'b1, 1'b0);
    push_item(8'hff, 1'b1, 1'b1, 1'b0);
    // The classic three-byte message "abc".
    push_item(8'h61, 1'b1, 1'b0, 1'b0);
    push_item(8'h62, 1'b1, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b1, 1'b0);
    // Two bytes with an idle item between them, closed by a finish with no byte.
    push_item(8'ha5, 1'b1, 1'b0, 1'b0);
    push_item(8'h3c, 1'b0, 1'b0, 1'b0);
    push_item(8'h5a, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1, 1'b0);

    // Random part. The first message ends where the length no longer fits in
    // the last block, so the padding needs a second one; the engine is drained
    // before it starts. The second ends just short of or exactly on a block.
    queue_message(56 + $urandom_range(7), 1'b1);
    queue_message($urandom_range(1) ? 55 : 64, 1'b0);
    // Mostly short messages, with some around one and two block lengths.
    while (random_items < 320) begin
      pick = $urandom_range(99);
      if (pick < 60) len = $urandom_range(12);
      else if (pick < 85) len = $urandom_range(70, 50);
      else len = $urandom_range(130, 115);
      queue_message(len, $urandom_range(3) == 0);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every digest word to arrive, then
    // keep watching a while for stray output.
    while (feed_queue.size() != 0 || data_valid || digest_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && digest_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sha256_pkg.sv
src/sha256_round.sv
src/sha256_hash_engine_core.sv
src/sha256_checker.sv
test/testbench.sv
